@@ hdl/stbs_pkg.sv @@
`default_nettype none
package stbs_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LEN_W  = 5;
    localparam int DATA_W = 32;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage
`default_nettype wire

@@ hdl/stbs_ram.sv @@
`default_nettype none
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/stbs_ctrl.sv @@
`default_nettype none
module stbs_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_op,
    input  wire logic [stbs_pkg::ADDR_W-1:0]    i_index,
    input  wire logic signed [stbs_pkg::DATA_W-1:0] i_value,
    input  wire logic [stbs_pkg::LEN_W-1:0]     i_len,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_found,
    output logic [stbs_pkg::ADDR_W-1:0]         o_position,
    output stbs_pkg::t_ram_req                  o_ram_req,
    input  wire logic [stbs_pkg::DATA_W-1:0]    i_ram_rdata
);
    import stbs_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_low, n_low;
    logic [CNT_W-1:0]    r_hi, n_hi;     // exclusive upper bound
    logic [ADDR_W-1:0]   r_mid, n_mid;
    logic [DATA_W-1:0]   r_key;
    logic                r_out_valid;
    logic                r_found;
    logic [ADDR_W-1:0]   r_pos;

    logic [CNT_W-1:0]    len_sat;
    logic [CNT_W:0]      sum_cur, sum_upd;
    logic [ADDR_W-1:0]   mid_cur, mid_upd;
    logic [CNT_W-1:0]    upd_low, upd_hi;
    logic                key_gt, key_eq;
    logic                slot_free;
    logic                done, hit;
    logic                accept;

    assign len_sat = (i_len > LEN_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(i_len);

    // mid = floor((low + high) / 2) with high = hi - 1
    assign sum_cur = {1'b0, r_low} + {1'b0, r_hi} - (CNT_W+1)'(1);
    assign mid_cur = sum_cur[ADDR_W:1];

    assign key_gt = $signed(r_key) > $signed(i_ram_rdata);
    assign key_eq = r_key == i_ram_rdata;

    always_comb begin
        upd_low = r_low;
        upd_hi  = r_hi;
        if (key_gt) begin
            upd_low = CNT_W'(r_mid) + CNT_W'(1);
        end else begin
            upd_hi = CNT_W'(r_mid);
        end
    end

    assign sum_upd = {1'b0, upd_low} + {1'b0, upd_hi} - (CNT_W+1)'(1);
    assign mid_upd = sum_upd[ADDR_W:1];

    assign slot_free = !r_out_valid || !i_stall;
    assign accept    = i_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_low     = r_low;
        n_hi      = r_hi;
        n_mid     = r_mid;
        done      = 1'b0;
        hit       = 1'b0;
        o_ram_req = '{we: 1'b0, waddr: i_index, wdata: i_value, re: 1'b0, raddr: mid_cur};
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (t_op'(i_op) == OP_SEARCH) begin
                        n_low   = '0;
                        n_hi    = len_sat;
                        n_state = ST_PROBE;
                    end else begin
                        o_ram_req.we = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (r_low < r_hi) begin
                    o_ram_req.re = 1'b1;
                    n_mid        = mid_cur;
                    n_state      = ST_CHECK;
                end else begin
                    done = 1'b1;
                end
            end
            ST_CHECK: begin
                if (key_eq) begin
                    done = 1'b1;
                    hit  = 1'b1;
                end else if (upd_low < upd_hi) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = mid_upd;
                    n_mid           = mid_upd;
                    n_low           = upd_low;
                    n_hi            = upd_hi;
                end else begin
                    done = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // hold the finished search until the output register frees up
        if (done && slot_free) begin
            n_state = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_low <= n_low;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        if (accept) begin
            r_key <= i_value;
        end
        if (done && slot_free) begin
            r_found <= hit;
            r_pos   <= hit ? r_mid : '0;
        end
    end

    assign o_stall    = r_state != ST_IDLE;
    assign o_valid    = r_out_valid;
    assign o_found    = r_found;
    assign o_position = r_pos;

endmodule
`default_nettype wire

@@ hdl/sorted_table_binary_search_unit.sv @@
// Write item: accepted with no result; the next item may follow at once.
// Search item: the first probe is formed, then one table read and compare per probe
// (one RAM read port), up to log2(DEPTH)+1 probes; a finished result waits for a free
// output register; the next item is taken the cycle after the result is registered.
// Synchronous active-low reset clears the length register, sequencer and output valid;
// table contents are not cleared and are undefined until written.
`default_nettype none
module sorted_table_binary_search_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [stbs_pkg::LEN_W-1:0]     i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_op,
    input  wire logic [stbs_pkg::ADDR_W-1:0]    i_index,
    input  wire logic signed [stbs_pkg::DATA_W-1:0] i_value,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_found,
    output logic [stbs_pkg::ADDR_W-1:0]         o_position
);
    import stbs_pkg::*;

    logic [LEN_W-1:0]  r_table_len;
    t_ram_req          ram_req;
    logic [DATA_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_len <= '0;
        end else if (i_cfg_we) begin
            r_table_len <= i_cfg_data;
        end
    end

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_len       (r_table_len),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

@@ test/tb_sorted_table_binary_search_unit.sv @@
`timescale 1ns / 100ps
module tb_sorted_table_binary_search_unit;
    import stbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int N_DIR          = 26;
    localparam int N_PHASES       = 28;
    localparam int PHASE_ITEMS    = 60;
    localparam int HOLD_CYCLES    = 300;
    // first lengths of the random part, low entry first
    localparam logic [8*LEN_W-1:0] LEN_SEQ = {5'd8, 5'd31, 5'd15, 5'd2, 5'd1, 5'd17, 5'd0, 5'd16};

    typedef enum logic {
        ROW_ITEM,
        ROW_LEN
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        t_op                      op;
        logic [ADDR_W-1:0]        idx;
        logic signed [DATA_W-1:0] val;
        logic                     fixed;
        logic                     found;
        logic [ADDR_W-1:0]        pos;
    } t_row;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] position;
    } t_res;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [LEN_W-1:0]         i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_op;
    logic [ADDR_W-1:0]        i_index;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic                     i_stall;
    logic                     o_found;
    logic [ADDR_W-1:0]        o_position;

    // expectation typed into the directed table, carried along with the item
    logic              dir_fixed;
    logic              dir_found;
    logic [ADDR_W-1:0] dir_pos;

    // search state mirrored at acceptance
    logic signed [DATA_W-1:0] shadow_tbl [DEPTH];
    logic [LEN_W-1:0]         shadow_len;
    t_res                     expected_hits [$];

    // sender's own view, ahead of acceptance
    logic signed [DATA_W-1:0] tx_tbl [DEPTH];
    logic [LEN_W-1:0]         tx_len = '0;

    bit   tx_gaps     = 1'b1;
    bit   rx_gaps     = 1'b1;
    int   rx_hold_len = 0;
    int   err_count   = 0;
    int   idle_cnt    = 0;
    t_row dir_rows [N_DIR];

    sorted_table_binary_search_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_index    (i_index),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_found    (o_found),
        .o_position (o_position)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // halve low..high over the mirrored table until the key is hit or the range is empty
    function automatic t_res locate_key(input logic signed [DATA_W-1:0] key);
        t_res r;
        int   lo;
        int   hi;
        int   mid;
        bit   done;
        r    = '0;
        done = 1'b0;
        lo   = 0;
        hi   = ((int'(shadow_len) > DEPTH) ? DEPTH : int'(shadow_len)) - 1;
        while (!done && lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key > shadow_tbl[mid]) begin
                lo = mid + 1;
            end else if (key < shadow_tbl[mid]) begin
                hi = mid - 1;
            end else begin
                r.found    = 1'b1;
                r.position = ADDR_W'(mid);
                done       = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_res want;
        if (!i_rst_n) begin
            shadow_len = '0;
        end else begin
            idle_cnt = idle_cnt + 1;
            if (i_cfg_we) begin
                shadow_len = i_cfg_data;
            end
            if (i_valid && o_stall === 1'b0) begin
                idle_cnt = 0;
                if (i_op == OP_WRITE) begin
                    shadow_tbl[i_index] = i_value;
                end else begin
                    if (dir_fixed) begin
                        want.found    = dir_found;
                        want.position = dir_pos;
                    end else begin
                        want = locate_key(i_value);
                    end
                    expected_hits.push_back(want);
                end
            end
            if (o_valid === 1'b1 && !i_stall) begin
                idle_cnt = 0;
                if (expected_hits.size() == 0) begin
                    report_mismatch($sformatf("result with no search pending (found %b pos %0d)",
                                              o_found, o_position));
                end else begin
                    want = expected_hits.pop_front();
                    if (o_found !== want.found)
                        report_mismatch($sformatf("found: expected %b, got %b",
                                                  want.found, o_found));
                    if (o_position !== want.position)
                        report_mismatch($sformatf("position: expected %0d, got %0d",
                                                  want.position, o_position));
                end
            end
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result side: draw a stall per result, or hold off for a long stretch on request
    initial begin : rx_side
        int wait_n;
        forever begin
            if (rx_hold_len > 0) begin
                wait_n      = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                wait_n = rx_gaps ? $urandom_range(0, 19) : 0;
            end
            if (wait_n > 0) begin
                i_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
        end
    end

    task automatic send_item(input t_op op, input logic [ADDR_W-1:0] idx,
                             input logic signed [DATA_W-1:0] val, input logic fixed,
                             input logic found, input logic [ADDR_W-1:0] pos);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_index   <= idx;
        i_value   <= val;
        dir_fixed <= fixed;
        dir_found <= found;
        dir_pos   <= pos;
        if (op == OP_WRITE) begin
            tx_tbl[idx] = val;
        end
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
    endtask

    // drop valid, wait for every pending result, then let the sequencer finish
    task automatic settle_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_table_len(input logic [LEN_W-1:0] len);
        settle_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        tx_len = len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int n_items);
        int                       k;
        int                       j;
        int                       eff;
        int                       pick;
        bit                       narrow;
        longint                   acc;
        logic signed [DATA_W-1:0] key;
        eff = (int'(tx_len) > DEPTH) ? DEPTH : int'(tx_len);
        if ($urandom_range(0, 2) == 0) begin
            // reload a sorted table; a narrow one repeats keys
            narrow = $urandom_range(0, 1);
            acc = narrow ? -longint'($urandom_range(0, 8))
                         : -64'sd2147483648 + longint'($urandom_range(0, 1 << 30));
            for (j = 0; j < DEPTH; j++) begin
                send_item(OP_WRITE, ADDR_W'(j), DATA_W'(acc), 1'b0, 1'b0, '0);
                acc += narrow ? $urandom_range(0, 3) : $urandom_range(0, 1 << 27);
            end
        end
        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                // stray write, leaves the table out of order
                send_item(OP_WRITE, ADDR_W'($urandom_range(0, DEPTH - 1)), $urandom(),
                          1'b0, 1'b0, '0);
            end else begin
                if (pick <= 4 && eff > 0) begin
                    key = tx_tbl[$urandom_range(0, eff - 1)];
                end else if (pick <= 6) begin
                    key = tx_tbl[$urandom_range(0, DEPTH - 1)];
                    key = $urandom_range(0, 1) ? key + 1 : key - 1;
                end else if (pick == 7) begin
                    case ($urandom_range(0, 3))
                        0: key = {1'b1, {(DATA_W - 1){1'b0}}};
                        1: key = {1'b0, {(DATA_W - 1){1'b1}}};
                        2: key = '0;
                        default: key = '1;
                    endcase
                end else begin
                    key = $urandom();
                end
                send_item(OP_SEARCH, ADDR_W'($urandom_range(0, DEPTH - 1)), key,
                          1'b0, 1'b0, '0);
            end
        end
    endtask

    initial begin
        int ph;
        int i;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_op       <= OP_WRITE;
        i_index    <= '0;
        i_value    <= '0;
        dir_fixed  <= 1'b0;
        dir_found  <= 1'b0;
        dir_pos    <= '0;

        dir_rows = '{
            // empty table after reset
            '{ROW_ITEM, OP_SEARCH, 4'd0,  32'sd0,             1'b1, 1'b0, 4'd0},
            '{ROW_ITEM, OP_SEARCH, 4'd15, 32'h7FFF_FFFF,      1'b1, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd15, 32'h7FFF_FFFF,      1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd0,  32'h8000_0000,      1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd1,  -32'sd1000000000,   1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd2,  -32'sd65536,        1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd3,  -32'sd1000,         1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd4,  -32'sd1,            1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd5,  32'sd0,             1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd6,  32'sd1,             1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd7,  32'sd7,             1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd8,  32'sd100,           1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd9,  32'sd4096,          1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd10, 32'sd65535,         1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd11, 32'sd1000000,       1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd12, 32'sd123456789,     1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd13, 32'sd1000000000,    1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_WRITE,  4'd14, 32'h7FFF_FFFE,      1'b0, 1'b0, 4'd0},
            // length beyond depth saturates to the full table
            '{ROW_LEN,  OP_WRITE,  4'd0,  32'sd31,            1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_SEARCH, 4'd0,  32'h8000_0000,      1'b1, 1'b1, 4'd0},
            '{ROW_ITEM, OP_SEARCH, 4'd0,  32'h7FFF_FFFF,      1'b1, 1'b1, 4'd15},
            '{ROW_ITEM, OP_SEARCH, 4'd9,  32'sd2,             1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_SEARCH, 4'd3,  32'sd7,             1'b0, 1'b0, 4'd0},
            '{ROW_LEN,  OP_WRITE,  4'd0,  32'sd1,             1'b0, 1'b0, 4'd0},
            '{ROW_ITEM, OP_SEARCH, 4'd0,  32'h8000_0000,      1'b1, 1'b1, 4'd0},
            '{ROW_ITEM, OP_SEARCH, 4'd0,  32'h7FFF_FFFF,      1'b1, 1'b0, 4'd0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].kind == ROW_LEN) begin
                set_table_len(dir_rows[i].val[LEN_W-1:0]);
            end else begin
                send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val,
                          dir_rows[i].fixed, dir_rows[i].found, dir_rows[i].pos);
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 8) begin
                set_table_len(LEN_SEQ[ph*LEN_W +: LEN_W]);
            end else begin
                set_table_len(LEN_W'($urandom_range(0, 31)));
            end
            tx_gaps = $urandom_range(0, 3) != 0;
            rx_gaps = $urandom_range(0, 3) != 0;
            if (ph == 3) begin
                // back up the result side so the block stalls its input
                tx_gaps     = 1'b0;
                rx_hold_len = HOLD_CYCLES;
            end
            run_phase(PHASE_ITEMS);
        end

        settle_block();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sorted_table_binary_search_unit.f @@
hdl/stbs_pkg.sv
hdl/stbs_ram.sv
hdl/stbs_ctrl.sv
hdl/sorted_table_binary_search_unit.sv
test/tb_sorted_table_binary_search_unit.sv
